// ----- hw/rtl/tpd_pkg.sv -----
`default_nettype none
package tpd_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int TW = 63;
    localparam int IC_W = 16;
    localparam logic [IC_W-1:0] IC_RESET = 16'd1000;
    localparam int DIV_W = 64;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    typedef struct packed {
        logic          req_type;
        logic [TW-1:0] sample_time;
        logic [TW-1:0] sample_level;
        logic          last_sample;
    } in_t;

    typedef struct packed {
        logic [TW-1:0] point_time;
        logic [TW-1:0] point_level;
        logic          final_point;
        logic          nothing_left;
        logic          overflowed;
    } out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_RD,
        ST_T_USE,
        ST_T_E,
        ST_G0,
        ST_G1,
        ST_G2,
        ST_G3,
        ST_F_INIT,
        ST_F_K,
        ST_F_KW,
        ST_F_NW,
        ST_F_CHK,
        ST_F_C1,
        ST_F_SC,
        ST_F_SW,
        ST_F_PUSH,
        ST_P_W1,
        ST_P_W2
    } st_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tpd_ram.sv -----
`default_nettype none
module tpd_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/tpd_div.sv -----
`default_nettype none
module tpd_div
    import tpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIV_W-1:0]  dividend,
    input  wire logic [IC_W-1:0]   divisor,
    output logic                   done,
    output logic      [DIV_W-1:0]  quotient,
    output logic                   rem_nz
);
    localparam int CNT_W = $clog2(DIV_W);

    logic [IC_W:0]      rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [IC_W-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [IC_W:0]      shifted;
    logic               take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        shifted   = {rem_reg[IC_W-1:0], quo_reg[DIV_W-1]};
        take      = (shifted >= {1'b0, dvs_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = take ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_next = {quo_reg[DIV_W-2:0], take};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = (rem_reg != '0);
endmodule
`default_nettype wire

// ----- hw/rtl/turning_point_downsampler_unit.sv -----
// Turning-point downsampler.
// A request is taken when start is high and busy is low. A load request
// (req_type 0) writes one sample into the sample memory, or once it is full
// drops it and flags overflowed; busy stays low, so loads can follow each
// other every cycle. A load marked last_sample starts the pass: busy stays
// high while the levels are walked to find the turning runs, the gap is
// computed by a serial divider, and the samples are walked again to insert
// fill points. The walks and the gap step share the one read port of the
// sample memory. A pull request (req_type 1) holds busy while the chosen
// index and then the sample are read; the result appears on result with
// result_valid high for one cycle, once busy is low again. A pull that finds
// no point answers with nothing_left in the cycle after the request.
// The receiver cannot stall; results are never held back.
// The user must write the interval count (cfg_we, cfg_data) only while idle;
// the block does not enforce it. Reset returns the block to loading with empty
// counts; memory contents are not cleared and no clearing pass is needed.
`default_nettype none
module turning_point_downsampler_unit
    import tpd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire in_t             req,
    output out_t                 result,
    output logic                 result_valid,
    input  wire logic            cfg_we,
    input  wire logic [IC_W-1:0] cfg_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    st_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next, cc_reg, cc_next, rp_reg, rp_next;
    logic [CW-1:0]   i_reg, i_next, tc_reg, tc_next, k_reg, k_next;
    logic            ready_reg, ready_next, drop_reg, drop_next, fin_reg, fin_next;
    logic            rv_reg, rv_next;
    logic [IC_W-1:0] ic_reg, ic_next;
    logic [AW-1:0]   s_reg, s_next, e_reg, e_next, last_reg, last_next;
    logic [AW-1:0]   nxt_reg, nxt_next, ins_reg, ins_next;
    logic [TW-1:0]   v_reg, v_next, bef_reg, bef_next, t0_reg, t0_next;
    logic [TW-1:0]   last_t_reg, last_t_next, nxt_t_reg, nxt_t_next;
    logic [TW-1:0]   cur_t_reg, cur_t_next;
    logic [DIV_W-1:0] gap_reg, gap_next, tgt_reg, tgt_next;
    out_t            res_reg, res_next;

    logic                smp_we, turn_we, ch_we;
    logic [AW-1:0]       smp_waddr, smp_raddr, turn_waddr, turn_wdata, ch_waddr, ch_wdata;
    logic [2*TW-1:0]     smp_wdata, smp_rdata;
    logic [AW-1:0]       turn_rdata, ch_rdata;
    logic [TW-1:0]       rd_t, rd_l;

    logic                div_start, div_done, div_rnz;
    logic [DIV_W-1:0]    div_q, span, step_dt;
    logic [IC_W-1:0]     ic_eff;
    logic [AW:0]         cand, nx1;
    logic [CW-1:0]       wcnt, cnt_m1;
    logic                peak;

    assign rd_t = smp_rdata[2*TW-1:TW];
    assign rd_l = smp_rdata[TW-1:0];
    assign ic_eff = (ic_reg == '0) ? IC_W'(1) : ic_reg;
    assign span = {1'b0, rd_t} - {1'b0, t0_reg};
    assign step_dt = {1'b0, nxt_t_reg} - {1'b0, last_t_reg};
    assign cand = {1'b0, last_reg} + 1'b1;
    assign nx1 = {1'b0, ins_reg} + 1'b1;
    assign cnt_m1 = cnt_reg - 1'b1;

    tpd_ram #(.W(2 * TW), .D(DEPTH)) u_smp (
        .clk(clk), .we(smp_we), .waddr(smp_waddr), .wdata(smp_wdata),
        .raddr(smp_raddr), .rdata(smp_rdata)
    );
    tpd_ram #(.W(AW), .D(DEPTH)) u_turn (
        .clk(clk), .we(turn_we), .waddr(turn_waddr), .wdata(turn_wdata),
        .raddr(k_reg[AW-1:0]), .rdata(turn_rdata)
    );
    tpd_ram #(.W(AW), .D(DEPTH)) u_chosen (
        .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(rp_reg[AW-1:0]), .rdata(ch_rdata)
    );
    tpd_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(span),
        .divisor(ic_eff), .done(div_done), .quotient(div_q), .rem_nz(div_rnz)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            cc_reg    <= '0;
            rp_reg    <= '0;
            i_reg     <= '0;
            tc_reg    <= '0;
            k_reg     <= '0;
            ready_reg <= 1'b0;
            drop_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            rv_reg    <= 1'b0;
            ic_reg    <= IC_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cc_reg    <= cc_next;
            rp_reg    <= rp_next;
            i_reg     <= i_next;
            tc_reg    <= tc_next;
            k_reg     <= k_next;
            ready_reg <= ready_next;
            drop_reg  <= drop_next;
            fin_reg   <= fin_next;
            rv_reg    <= rv_next;
            ic_reg    <= ic_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        e_reg      <= e_next;
        last_reg   <= last_next;
        nxt_reg    <= nxt_next;
        ins_reg    <= ins_next;
        v_reg      <= v_next;
        bef_reg    <= bef_next;
        t0_reg     <= t0_next;
        last_t_reg <= last_t_next;
        nxt_t_reg  <= nxt_t_next;
        cur_t_reg  <= cur_t_next;
        gap_reg    <= gap_next;
        tgt_reg    <= tgt_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cc_next     = cc_reg;
        rp_next     = rp_reg;
        i_next      = i_reg;
        tc_next     = tc_reg;
        k_next      = k_reg;
        ready_next  = ready_reg;
        drop_next   = drop_reg;
        fin_next    = fin_reg;
        rv_next     = 1'b0;
        ic_next     = cfg_we ? cfg_data : ic_reg;
        s_next      = s_reg;
        e_next      = e_reg;
        last_next   = last_reg;
        nxt_next    = nxt_reg;
        ins_next    = ins_reg;
        v_next      = v_reg;
        bef_next    = bef_reg;
        t0_next     = t0_reg;
        last_t_next = last_t_reg;
        nxt_t_next  = nxt_t_reg;
        cur_t_next  = cur_t_reg;
        gap_next    = gap_reg;
        tgt_next    = tgt_reg;
        res_next    = res_reg;
        smp_we      = 1'b0;
        smp_waddr   = '0;
        smp_wdata   = {req.sample_time, req.sample_level};
        smp_raddr   = '0;
        turn_we     = 1'b0;
        turn_waddr  = tc_reg[AW-1:0];
        turn_wdata  = s_reg;
        ch_we       = 1'b0;
        ch_waddr    = cc_reg[AW-1:0];
        ch_wdata    = nxt_reg;
        div_start   = 1'b0;
        wcnt        = cnt_reg;
        peak        = ((v_reg > bef_reg) && (v_reg > rd_l))
                   || ((v_reg < bef_reg) && (v_reg < rd_l));
        busy        = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (req.req_type == REQ_LOAD))
                begin
                    if (ready_reg)
                    begin
                        wcnt       = '0;
                        drop_next  = 1'b0;
                        cc_next    = '0;
                        rp_next    = '0;
                        ready_next = 1'b0;
                    end
                    cnt_next = wcnt;
                    if (wcnt != DEPTH_C)
                    begin
                        smp_we    = 1'b1;
                        smp_waddr = wcnt[AW-1:0];
                        cnt_next  = wcnt + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (req.last_sample)
                    begin
                        i_next     = '0;
                        tc_next    = '0;
                        fin_next   = 1'b0;
                        s_next     = '0;
                        state_next = ST_T_RD;
                    end
                end
                else if (start)
                begin
                    if (ready_reg && (rp_reg < cc_reg))
                    begin
                        state_next = ST_P_W1;
                    end
                    else
                    begin
                        res_next            = '0;
                        res_next.nothing_left = 1'b1;
                        res_next.overflowed = drop_reg;
                        rv_next             = 1'b1;
                    end
                end
            end
            ST_T_RD:
            begin
                if (i_reg != cnt_reg)
                begin
                    smp_raddr  = i_reg[AW-1:0];
                    state_next = ST_T_USE;
                end
                else if (!fin_reg)
                begin
                    turn_we  = 1'b1;
                    tc_next  = tc_reg + 1'b1;
                    fin_next = 1'b1;
                    e_next   = cnt_m1[AW-1:0];
                    state_next = (cnt_m1[AW-1:0] != s_reg) ? ST_T_E : ST_G0;
                end
                else
                begin
                    state_next = ST_G0;
                end
            end
            ST_T_USE:
            begin
                i_next     = i_reg + 1'b1;
                state_next = ST_T_RD;
                if (i_reg == '0)
                begin
                    v_next = rd_l;
                end
                else if (rd_l != v_reg)
                begin
                    e_next = i_reg[AW-1:0] - 1'b1;
                    if ((s_reg == '0) || peak)
                    begin
                        turn_we = 1'b1;
                        tc_next = tc_reg + 1'b1;
                        if (i_reg[AW-1:0] - 1'b1 != s_reg)
                        begin
                            state_next = ST_T_E;
                        end
                    end
                    bef_next = v_reg;
                    v_next   = rd_l;
                    s_next   = i_reg[AW-1:0];
                end
            end
            ST_T_E:
            begin
                turn_we    = 1'b1;
                turn_wdata = e_reg;
                tc_next    = tc_reg + 1'b1;
                state_next = ST_T_RD;
            end
            ST_G0:
            begin
                smp_raddr  = '0;
                state_next = ST_G1;
            end
            ST_G1:
            begin
                t0_next    = rd_t;
                smp_raddr  = cnt_m1[AW-1:0];
                state_next = ST_G2;
            end
            ST_G2:
            begin
                if (span[DIV_W-1] || (span == '0))
                begin
                    gap_next   = DIV_W'(1);
                    state_next = ST_F_INIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_G3;
                end
            end
            ST_G3:
            begin
                if (div_done)
                begin
                    gap_next   = div_q + DIV_W'(div_rnz);
                    state_next = ST_F_INIT;
                end
            end
            ST_F_INIT:
            begin
                ch_we       = 1'b1;
                ch_waddr    = '0;
                ch_wdata    = '0;
                cc_next     = CW'(1);
                last_next   = '0;
                last_t_next = t0_reg;
                k_next      = CW'(1);
                state_next  = ST_F_K;
            end
            ST_F_K:
            begin
                if (k_reg == tc_reg)
                begin
                    ready_next = 1'b1;
                    rp_next    = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_F_KW;
                end
            end
            ST_F_KW:
            begin
                nxt_next   = turn_rdata;
                smp_raddr  = turn_rdata;
                state_next = ST_F_NW;
            end
            ST_F_NW:
            begin
                nxt_t_next = rd_t;
                state_next = ST_F_CHK;
            end
            ST_F_CHK:
            begin
                if ((cand < {1'b0, nxt_reg}) && !step_dt[DIV_W-1] && (step_dt > gap_reg))
                begin
                    tgt_next   = {1'b0, last_t_reg} + gap_reg;
                    smp_raddr  = cand[AW-1:0];
                    ins_next   = cand[AW-1:0];
                    state_next = ST_F_C1;
                end
                else
                begin
                    ch_we       = 1'b1;
                    cc_next     = cc_reg + 1'b1;
                    last_next   = nxt_reg;
                    last_t_next = nxt_t_reg;
                    k_next      = k_reg + 1'b1;
                    state_next  = ST_F_K;
                end
            end
            ST_F_C1:
            begin
                cur_t_next = rd_t;
                state_next = ST_F_SC;
            end
            ST_F_SC:
            begin
                if (nx1 < {1'b0, nxt_reg})
                begin
                    smp_raddr  = nx1[AW-1:0];
                    state_next = ST_F_SW;
                end
                else
                begin
                    state_next = ST_F_PUSH;
                end
            end
            ST_F_SW:
            begin
                if ({1'b0, rd_t} <= tgt_reg)
                begin
                    ins_next   = nx1[AW-1:0];
                    cur_t_next = rd_t;
                    state_next = ST_F_SC;
                end
                else
                begin
                    state_next = ST_F_PUSH;
                end
            end
            ST_F_PUSH:
            begin
                ch_we       = 1'b1;
                ch_wdata    = ins_reg;
                cc_next     = cc_reg + 1'b1;
                last_next   = ins_reg;
                last_t_next = cur_t_reg;
                state_next  = ST_F_CHK;
            end
            ST_P_W1:
            begin
                smp_raddr  = ch_rdata;
                state_next = ST_P_W2;
            end
            ST_P_W2:
            begin
                res_next.point_time   = rd_t;
                res_next.point_level  = rd_l;
                res_next.final_point  = ((rp_reg + 1'b1) == cc_reg);
                res_next.nothing_left = 1'b0;
                res_next.overflowed   = drop_reg;
                rv_next               = 1'b1;
                rp_next               = rp_reg + 1'b1;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result       = res_reg;
    assign result_valid = rv_reg;

`ifndef SYNTHESIS
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.nothing_left) |->
        (result.point_time == '0 && result.point_level == '0 && !result.final_point))
        else $error("empty result carries data");
    a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (rp_reg <= cc_reg))
        else $error("read pointer past chosen count");
    a_turn_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_F_K) |-> (k_reg <= tc_reg && tc_reg <= cnt_reg))
        else $error("turn index out of range");
`endif
endmodule
`default_nettype wire
